// File: hw/rtl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by the controller, the datapath and the top level; depends on nothing.
package pse_pkg;

    localparam int DATA_W = 32;
    localparam int CHAR_W = 8;

    // Character codes that the evaluator recognizes.
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       latch;      // capture the accepted character
        logic       push;       // push the latched digit
        logic       err_set;    // record a sticky error
        logic [1:0] err_val;
        logic       alu_load;   // load the add/sub/mul result
        logic       div_start;  // start the divider
        logic       div_load;   // load the quotient
        logic       pop_write;  // write the result over the left operand and pop one
        logic       emit;       // load the output register and clear the stack
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err_active;
        logic is_digit;
        logic is_op;
        logic is_div;
        logic full;
        logic lt2;
        logic rhs_zero;
        logic div_done;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// File: hw/rtl/pse_div.sv
// Iterative 32-bit signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pse_pkg for the data width.
module pse_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pse_pkg::DATA_W-1:0]          dividend,
    input  logic [pse_pkg::DATA_W-1:0]          divisor,
    output logic                                done,
    output logic [pse_pkg::DATA_W-1:0]          quotient
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int NW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic          neg_reg;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W-1:0]  shifted;
    logic [W:0]    trial;

    // One restoring step on the magnitudes.
    always_comb
    begin
        shifted   = {rem_reg[W-2:0], quo_reg[W-1]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            rem_next = trial[W] ? shifted : trial[W-1:0];
            quo_next = {quo_reg[W-2:0], ~trial[W]};
            cnt_next = cnt_reg - NW'(1);
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state of the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= NW'(W);
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[W-1] ? (W'(0) - dividend) : dividend;
            dvs_reg <= divisor[W-1] ? (W'(0) - divisor) : divisor;
            neg_reg <= dividend[W-1] ^ divisor[W-1];
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// File: hw/rtl/pse_datapath.sv
// Datapath of the evaluator: operand stack memory, count, sticky error, ALU,
// divider and output register. Depends on pse_pkg and pse_div.
module pse_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pse_pkg::cmd_t                       cmd,
    output pse_pkg::sts_t                       sts,
    input  logic [pse_pkg::CHAR_W-1:0]          in_char,
    input  logic                                in_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [pse_pkg::DATA_W-1:0]   out_value,
    output logic [1:0]                          out_status
);

    localparam int W  = pse_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [pse_pkg::CHAR_W-1:0] char_reg;
    logic                       last_reg;
    logic [CW-1:0]              count_reg;
    logic [1:0]                 err_reg;
    logic [W-1:0]               res_reg;
    logic [W-1:0]               rd_top_reg;
    logic [W-1:0]               rd_nxt_reg;
    logic [W-1:0]               mem [STACK_DEPTH];
    logic                       out_valid_reg;
    logic [W-1:0]               out_value_reg;
    logic [1:0]                 out_status_reg;

    logic [CW-1:0]              cnt_m1;
    logic [CW-1:0]              cnt_m2;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [W-1:0]               wdata;
    logic [pse_pkg::CHAR_W-1:0] digit_val;
    logic [2*W-1:0]             product;
    logic [W-1:0]               alu_res;
    logic                       div_done;
    logic [W-1:0]               div_q;
    logic                       out_free;

    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign digit_val = char_reg - pse_pkg::CH_ZERO;
    assign out_free  = !out_valid_reg || out_ready;

    // Decode of the latched character and stack conditions.
    always_comb
    begin
        sts.err_active = (err_reg != pse_pkg::ST_OK);
        sts.is_digit   = char_reg inside {[pse_pkg::CH_ZERO:pse_pkg::CH_NINE]};
        sts.is_op      = char_reg inside {pse_pkg::CH_PLUS, pse_pkg::CH_MINUS,
                                          pse_pkg::CH_MUL, pse_pkg::CH_DIV};
        sts.is_div     = (char_reg == pse_pkg::CH_DIV);
        sts.full       = (count_reg >= CW'(STACK_DEPTH));
        sts.lt2        = (count_reg < CW'(2));
        sts.rhs_zero   = (rd_top_reg == '0);
        sts.div_done   = div_done;
        sts.last       = last_reg;
        sts.out_free   = out_free;
    end

    // Add, subtract and low half of the product.
    always_comb
    begin
        product = rd_nxt_reg * rd_top_reg;
        case (char_reg)
            pse_pkg::CH_PLUS:  alu_res = rd_nxt_reg + rd_top_reg;
            pse_pkg::CH_MINUS: alu_res = rd_nxt_reg - rd_top_reg;
            default:           alu_res = product[W-1:0];
        endcase
    end

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_nxt_reg),
        .divisor  (rd_top_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Stack write port: a pushed digit or an operator result.
    always_comb
    begin
        we    = cmd.push || cmd.pop_write;
        waddr = cmd.push ? count_reg[AW-1:0] : cnt_m2[AW-1:0];
        wdata = cmd.push ? {{(W - pse_pkg::CHAR_W){1'b0}}, digit_val} : res_reg;
    end

    // Operand stack memory with registered reads of the two top entries.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_top_reg <= mem[cnt_m1[AW-1:0]];
        rd_nxt_reg <= mem[cnt_m2[AW-1:0]];
    end

    // Payload registers: latched character and operation result.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            char_reg <= in_char;
            last_reg <= in_last;
        end
        if (cmd.alu_load)
        begin
            res_reg <= alu_res;
        end
        else if (cmd.div_load)
        begin
            res_reg <= div_q;
        end
    end

    // Stack count and sticky error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= pse_pkg::ST_OK;
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            err_reg   <= pse_pkg::ST_OK;
        end
        else
        begin
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop_write)
            begin
                count_reg <= cnt_m1;
            end
            if (cmd.err_set)
            begin
                err_reg <= cmd.err_val;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: the top of stack, or zero with the failing status.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (err_reg != pse_pkg::ST_OK)
            begin
                out_value_reg  <= '0;
                out_status_reg <= err_reg;
            end
            else if (count_reg == '0)
            begin
                out_value_reg  <= '0;
                out_status_reg <= pse_pkg::ST_UNDER;
            end
            else
            begin
                out_value_reg  <= rd_top_reg;
                out_status_reg <= pse_pkg::ST_OK;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

// File: hw/rtl/pse_ctrl.sv
// Controller state machine of the evaluator; sequences one character at a time.
// Depends on pse_pkg for the command and status structs.
module pse_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pse_pkg::sts_t  sts,
    output pse_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] state_reg, state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_END;
                if (!sts.err_active)
                begin
                    if (sts.is_digit)
                    begin
                        if (sts.full)
                        begin
                            cmd.err_set = 1'b1;
                            cmd.err_val = pse_pkg::ST_OVER;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    else if (sts.is_op)
                    begin
                        if (sts.lt2)
                        begin
                            cmd.err_set = 1'b1;
                            cmd.err_val = pse_pkg::ST_UNDER;
                        end
                        else
                        begin
                            state_next = S_EXEC;
                        end
                    end
                end
            end
            S_EXEC:
            begin
                if (!sts.is_div)
                begin
                    cmd.alu_load = 1'b1;
                    state_next   = S_WB;
                end
                else if (sts.rhs_zero)
                begin
                    cmd.err_set = 1'b1;
                    cmd.err_val = pse_pkg::ST_DIVZERO;
                    state_next  = S_END;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_WB;
                end
            end
            S_WB:
            begin
                cmd.pop_write = 1'b1;
                state_next    = S_END;
            end
            S_END:
            begin
                // This cycle lets the stack read settle on the final count.
                state_next = sts.last ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/postfix_stack_evaluator_top.sv
// Postfix expression evaluator: one ASCII character per input transfer.
// Digits, ignored characters and stack errors go through decode and end states; a zero
// divisor adds execute, + - * add execute and write-back, and / also waits on the 32-step
// divider; a final character then loads the result in the emit state, which waits on a stall.
// rst_n is asynchronous, active low: the stack is empty, no error, no result pending.
// Stack contents are not cleared by reset; only entries below the count are read.
module postfix_stack_evaluator_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] char_code
    input  logic               s_tlast,   // end_of_expr
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic signed [31:0] m_tdata,   // [31:0] value
    output logic [1:0]         m_tuser    // [1:0] status
);

    pse_pkg::cmd_t cmd;
    pse_pkg::sts_t sts;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_char    (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser)
    );

endmodule

// File: hw/rtl/pse_checker.sv
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends only on the top-level ports.
module pse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds its value and status.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A failing status always carries a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 2'd0) |-> (m_tdata == 32'd0))
        else $error("nonzero value with error status");

    // Characters are taken one at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a character is in work");

    // No result can appear in the cycle right after a character transfer.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (.*);
